// ===== hdl/pms_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pms_pkg
// Shared constants and item types for the particle motion step pipeline.
// ----------------------------------------------------------------------------
package pms_pkg;

  localparam int STEP_DIVISOR = 48;
  localparam int DIV_W = $clog2(STEP_DIVISOR + 1);
  // Reciprocal for the position step; the estimate is at most one below the
  // true quotient and gets a single correction.
  localparam logic [32:0] RECIP = 33'((64'd1 << 32) / STEP_DIVISOR);
  localparam longint QMAX = (64'sd1 <<< 31) / STEP_DIVISOR;

  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS = 31;

  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [2:0][31:0] npos;
    logic [2:0][31:0] vel;
    logic [15:0]      nage;
    logic             keep;
  } pass_t;

  typedef struct packed {
    pass_t            pass;
    logic [2:0][61:0] num;
  } side_t;

endpackage

`default_nettype wire

// ===== hdl/particle_motion_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Pipeline: 5 front stages, 32 square-root stages, 31 divider stages and
// 1 output register lie between input accept and result valid.
// Throughput: one item per cycle; the whole pipeline advances whenever the
// output register is empty or being taken.
// Reset: synchronous, active low, clears all valid bits; data is not reset.
// ----------------------------------------------------------------------------
// particle_motion_step
// One Euler tick with friction for a stream of particle records.
// ----------------------------------------------------------------------------
module particle_motion_step (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] in_pos_x,
  input  wire logic signed [31:0] in_pos_y,
  input  wire logic signed [31:0] in_pos_z,
  input  wire logic signed [31:0] in_vel_x,
  input  wire logic signed [31:0] in_vel_y,
  input  wire logic signed [31:0] in_vel_z,
  input  wire logic [30:0]        in_drag,
  input  wire logic [15:0]        in_age,
  input  wire logic [15:0]        in_life_span,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_prev_pos_x,
  output logic signed [31:0]      out_prev_pos_y,
  output logic signed [31:0]      out_prev_pos_z,
  output logic signed [31:0]      out_new_pos_x,
  output logic signed [31:0]      out_new_pos_y,
  output logic signed [31:0]      out_new_pos_z,
  output logic signed [31:0]      out_new_vel_x,
  output logic signed [31:0]      out_new_vel_y,
  output logic signed [31:0]      out_new_vel_z,
  output logic [15:0]             out_new_age,
  output logic                    out_keep
);

  logic             en;
  logic             f_vld, s_vld, d_vld;
  logic [63:0]      f_sum;
  logic [31:0]      s_len;
  pms_pkg::side_t   f_side, s_side;
  pms_pkg::pass_t   d_pass;
  logic [2:0][30:0] d_dm;
  logic [2:0][31:0] vel_nxt;

  logic             out_valid_r;
  pms_pkg::pass_t   pass_r;
  logic [2:0][31:0] vel_r;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  pms_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (in_valid),
    .in_pos   ({in_pos_z, in_pos_y, in_pos_x}),
    .in_vel   ({in_vel_z, in_vel_y, in_vel_x}),
    .in_drag  (in_drag),
    .in_age   (in_age),
    .in_span  (in_life_span),
    .out_vld  (f_vld),
    .out_sum  (f_sum),
    .out_side (f_side)
  );

  pms_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (f_vld),
    .in_sum   (f_sum),
    .in_side  (f_side),
    .out_vld  (s_vld),
    .out_len  (s_len),
    .out_side (s_side)
  );

  pms_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (s_vld),
    .in_len   (s_len),
    .in_side  (s_side),
    .out_vld  (d_vld),
    .out_dm   (d_dm),
    .out_pass (d_pass)
  );

  // Friction is applied against the sign of each axis, then saturated.
  always_comb begin
    logic signed [32:0] d, diff;
    for (int i = 0; i < 3; i++) begin
      d    = d_pass.vel[i][31] ? -$signed({2'b00, d_dm[i]}) : $signed({2'b00, d_dm[i]});
      diff = $signed({d_pass.vel[i][31], d_pass.vel[i]}) - d;
      if (diff[32] != diff[31]) begin
        vel_nxt[i] = diff[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
        vel_nxt[i] = diff[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pass_r <= d_pass;
      vel_r  <= vel_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_prev_pos_x = pass_r.pos[0];
  assign out_prev_pos_y = pass_r.pos[1];
  assign out_prev_pos_z = pass_r.pos[2];
  assign out_new_pos_x  = pass_r.npos[0];
  assign out_new_pos_y  = pass_r.npos[1];
  assign out_new_pos_z  = pass_r.npos[2];
  assign out_new_vel_x  = vel_r[0];
  assign out_new_vel_y  = vel_r[1];
  assign out_new_vel_z  = vel_r[2];
  assign out_new_age    = pass_r.nage;
  assign out_keep       = pass_r.keep;

`ifndef SYNTHESIS
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($signed(32'(out_new_pos_x - out_prev_pos_x)) <= pms_pkg::QMAX) &&
                  ($signed(32'(out_new_pos_x - out_prev_pos_x)) >= -pms_pkg::QMAX))
    else $error("position step exceeds velocity range");
`endif

endmodule

`default_nettype wire

// ===== hdl/pms_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pms_front
// Five stages: magnitudes, squares and products, length sum, remainder, step.
// ----------------------------------------------------------------------------
module pms_front (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  en,
  input  wire logic                  in_vld,
  input  wire logic [2:0][31:0]      in_pos,
  input  wire logic [2:0][31:0]      in_vel,
  input  wire logic [30:0]           in_drag,
  input  wire logic [15:0]           in_age,
  input  wire logic [15:0]           in_span,
  output logic                       out_vld,
  output logic [63:0]                out_sum,
  output pms_pkg::side_t             out_side
);

  localparam int QD_W = 32 + pms_pkg::DIV_W;

  logic             v1_r, v2_r, v3_r, v4_r, v5_r;
  logic [2:0][31:0] pos1_r, pos2_r, pos3_r, pos4_r;
  logic [2:0][31:0] vel1_r, vel2_r, vel3_r, vel4_r;
  logic [2:0][31:0] mag1_r, mag2_r, mag3_r, mag4_r;
  logic [30:0]      drag1_r;
  logic [15:0]      nage1_r, nage2_r, nage3_r, nage4_r;
  logic             keep1_r, keep2_r, keep3_r, keep4_r;
  logic [2:0][63:0] sq2_r;
  logic [2:0][64:0] pr2_r;
  logic [2:0][61:0] num2_r, num3_r, num4_r;
  logic [63:0]      sum3_r, sum4_r;
  logic [2:0][31:0] qe3_r, qe4_r;
  logic [2:0][QD_W-1:0] qd4_r;
  pms_pkg::side_t   side5_r;
  logic [63:0]      sum5_r;

  logic [2:0][31:0] mag_nxt;
  logic [2:0][62:0] prod_nxt;
  logic [2:0][31:0] rem_nxt, q_nxt, npos_nxt;
  logic [15:0]      nage_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_nxt[i]  = in_vel[i][31] ? 32'(-in_vel[i]) : in_vel[i];
      prod_nxt[i] = drag1_r * mag1_r[i];
      rem_nxt[i]  = mag4_r[i] - qd4_r[i][31:0];
      q_nxt[i]    = (rem_nxt[i] >= 32'(pms_pkg::STEP_DIVISOR)) ? qe4_r[i] + 32'd1 : qe4_r[i];
      npos_nxt[i] = vel4_r[i][31] ? pos4_r[i] - q_nxt[i] : pos4_r[i] + q_nxt[i];
    end
    nage_nxt = in_age + 16'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pos1_r  <= in_pos;
      vel1_r  <= in_vel;
      mag1_r  <= mag_nxt;
      drag1_r <= in_drag;
      nage1_r <= nage_nxt;
      keep1_r <= (nage_nxt != in_span);

      pos2_r  <= pos1_r;
      vel2_r  <= vel1_r;
      mag2_r  <= mag1_r;
      nage2_r <= nage1_r;
      keep2_r <= keep1_r;
      for (int i = 0; i < 3; i++) begin
        sq2_r[i]  <= mag1_r[i] * mag1_r[i];
        pr2_r[i]  <= mag1_r[i] * pms_pkg::RECIP;
        num2_r[i] <= prod_nxt[i][61:0];
      end

      pos3_r  <= pos2_r;
      vel3_r  <= vel2_r;
      mag3_r  <= mag2_r;
      nage3_r <= nage2_r;
      keep3_r <= keep2_r;
      num3_r  <= num2_r;
      sum3_r  <= sq2_r[0] + sq2_r[1] + sq2_r[2];
      for (int i = 0; i < 3; i++) begin
        qe3_r[i] <= pr2_r[i][63:32];
      end

      pos4_r  <= pos3_r;
      vel4_r  <= vel3_r;
      mag4_r  <= mag3_r;
      nage4_r <= nage3_r;
      keep4_r <= keep3_r;
      num4_r  <= num3_r;
      sum4_r  <= sum3_r;
      qe4_r   <= qe3_r;
      for (int i = 0; i < 3; i++) begin
        qd4_r[i] <= qe3_r[i] * (pms_pkg::DIV_W)'(pms_pkg::STEP_DIVISOR);
      end

      side5_r.pass.pos  <= pos4_r;
      side5_r.pass.npos <= npos_nxt;
      side5_r.pass.vel  <= vel4_r;
      side5_r.pass.nage <= nage4_r;
      side5_r.pass.keep <= keep4_r;
      side5_r.num       <= num4_r;
      sum5_r            <= sum4_r;
    end
  end

  assign out_vld  = v5_r;
  assign out_sum  = sum5_r;
  assign out_side = side5_r;

endmodule

`default_nettype wire

// ===== hdl/pms_sqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pms_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module pms_sqrt (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           en,
  input  wire logic           in_vld,
  input  wire logic [63:0]    in_sum,
  input  wire pms_pkg::side_t in_side,
  output logic                out_vld,
  output logic [31:0]         out_len,
  output pms_pkg::side_t      out_side
);

  localparam int N = pms_pkg::SQRT_STEPS;

  logic           vld_r  [1:N];
  logic [33:0]    rem_r  [1:N];
  logic [31:0]    root_r [1:N];
  logic [63:0]    nsh_r  [1:N];
  pms_pkg::side_t side_r [1:N];

  for (genvar k = 0; k < N; k++) begin : g_st
    logic           c_vld;
    logic [33:0]    c_rem;
    logic [31:0]    c_root;
    logic [63:0]    c_nsh;
    pms_pkg::side_t c_side;
    logic [35:0]    t, trial;

    if (k == 0) begin : g_first
      assign c_vld  = in_vld;
      assign c_rem  = '0;
      assign c_root = '0;
      assign c_nsh  = in_sum;
      assign c_side = in_side;
    end else begin : g_rest
      assign c_vld  = vld_r[k];
      assign c_rem  = rem_r[k];
      assign c_root = root_r[k];
      assign c_nsh  = nsh_r[k];
      assign c_side = side_r[k];
    end

    assign t     = {c_rem, c_nsh[63:62]};
    assign trial = {2'b00, c_root, 2'b01};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= c_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (t >= trial) begin
          rem_r[k+1]  <= 34'(t - trial);
          root_r[k+1] <= {c_root[30:0], 1'b1};
        end else begin
          rem_r[k+1]  <= t[33:0];
          root_r[k+1] <= {c_root[30:0], 1'b0};
        end
        nsh_r[k+1]  <= {c_nsh[61:0], 2'b00};
        side_r[k+1] <= c_side;
      end
    end
  end

  assign out_vld  = vld_r[N];
  assign out_len  = root_r[N];
  assign out_side = side_r[N];

endmodule

`default_nettype wire

// ===== hdl/pms_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pms_div
// Pipelined restoring divider, three lanes, one quotient bit per stage.
// ----------------------------------------------------------------------------
module pms_div (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           en,
  input  wire logic           in_vld,
  input  wire logic [31:0]    in_len,
  input  wire pms_pkg::side_t in_side,
  output logic                out_vld,
  output logic [2:0][30:0]    out_dm,
  output pms_pkg::pass_t      out_pass
);

  localparam int N = pms_pkg::DIV_STEPS;

  logic             vld_r  [1:N];
  logic [31:0]      len_r  [1:N];
  logic [2:0][31:0] r_r    [1:N];
  logic [2:0][30:0] q_r    [1:N];
  logic [2:0][30:0] nsh_r  [1:N];
  pms_pkg::pass_t   pass_r [1:N];

  for (genvar k = 0; k < N; k++) begin : g_st
    logic             c_vld;
    logic [31:0]      c_len;
    logic [2:0][31:0] c_r;
    logic [2:0][30:0] c_q, c_nsh;
    pms_pkg::pass_t   c_pass;
    logic [2:0][32:0] t;

    if (k == 0) begin : g_first
      // The quotient never exceeds the drag, so the upper numerator half is
      // already below the length and can seed the remainder.
      always_comb begin
        for (int i = 0; i < 3; i++) begin
          c_r[i]   = {1'b0, in_side.num[i][61:31]};
          c_nsh[i] = in_side.num[i][30:0];
        end
      end
      assign c_vld  = in_vld;
      assign c_len  = in_len;
      assign c_q    = '0;
      assign c_pass = in_side.pass;
    end else begin : g_rest
      assign c_vld  = vld_r[k];
      assign c_len  = len_r[k];
      assign c_r    = r_r[k];
      assign c_q    = q_r[k];
      assign c_nsh  = nsh_r[k];
      assign c_pass = pass_r[k];
    end

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        t[i] = {c_r[i], c_nsh[i][30]};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= c_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          if (t[i] >= {1'b0, c_len}) begin
            r_r[k+1][i] <= 32'(t[i] - {1'b0, c_len});
            q_r[k+1][i] <= {c_q[i][29:0], 1'b1};
          end else begin
            r_r[k+1][i] <= t[i][31:0];
            q_r[k+1][i] <= {c_q[i][29:0], 1'b0};
          end
          nsh_r[k+1][i] <= {c_nsh[i][29:0], 1'b0};
        end
        len_r[k+1]  <= c_len;
        pass_r[k+1] <= c_pass;
      end
    end
  end

  // A zero length means a zero velocity, which takes no friction.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      out_dm[i] = (len_r[N] == 32'd0) ? 31'd0 : q_r[N][i];
    end
  end

  assign out_vld  = vld_r[N];
  assign out_pass = pass_r[N];

endmodule

`default_nettype wire
